/* sv/ece_pkg.sv */
package ece_pkg;

  localparam int FRAC_BITS = 15;
  localparam int VW = 16;
  localparam logic [VW-1:0] ONE = VW'(1 << FRAC_BITS);

  localparam logic [1:0] MODE_SLOW_OUT = 2'd0;
  localparam logic [1:0] MODE_SLOW_IN  = 2'd1;

  localparam logic [2:0] REG_CURVE_MODE = 3'd0;
  localparam logic [2:0] REG_POINT1_X   = 3'd1;
  localparam logic [2:0] REG_POINT1_Y   = 3'd2;
  localparam logic [2:0] REG_POINT2_X   = 3'd3;
  localparam logic [2:0] REG_POINT2_Y   = 3'd4;
  localparam logic [2:0] REG_POINT3_X   = 3'd5;
  localparam logic [2:0] REG_POINT3_Y   = 3'd6;
  localparam logic [2:0] REG_POINT4_Y   = 3'd7;

  // Quotient bits: numerator < 2^16, shifted by FRAC_BITS.
  localparam int QW = VW + FRAC_BITS;

  // Classified item that travels from front to back.
  typedef struct packed {
    logic [VW-1:0] num;
    logic [VW-1:0] den;
    logic          zero;
    logic          quad;
    logic [VW-1:0] ya;
    logic [VW-1:0] yb;
    logic [VW-1:0] yc;
    logic [1:0]    seg;
  } job_t;

  typedef struct packed {
    logic [VW-1:0] eased_value;
    logic [1:0]    segment;
  } res_t;

endpackage

/* sv/ece_if.sv */
interface ece_in_if;
  import ece_pkg::*;
  logic          valid;
  logic          ready;
  logic [VW-1:0] time_in;
  modport source (output valid, output time_in, input ready);
  modport sink (input valid, input time_in, output ready);
endinterface

interface ece_out_if;
  import ece_pkg::*;
  logic          valid;
  logic          ready;
  logic [VW-1:0] eased_value;
  logic [1:0]    segment;
  modport source (output valid, output eased_value, output segment, input ready);
  modport sink (input valid, input eased_value, input segment, output ready);
endinterface

interface ece_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/easing_curve_evaluator_unit.sv */
// Easing curve evaluator.
// in_*:  valid/ready channel carrying time_in, unsigned Q1.15 (32768 = 1.0).
// out_*: valid/ready channel carrying eased_value (Q1.15, 0..32768) and the
//        segment index that t fell in.
// cfg_*: write channel; cfg_index selects curve_mode, point1_x .. point4_y
//        (indices 0..7), cfg_data is the value. Always ready; writes to
//        other indices are dropped. Write only while the block is idle.
// Throughput: one item per cycle while no result is held waiting on out_ready.
// Path from acceptance to out_valid: one front register, one queue slot,
//   the divider input register, a 31-stage restoring divider (one quotient
//   bit per stage), weight, product, sum stages and the output register.
// The front classifies t and picks the segment; a two-entry queue lets the
// front and back pipeline stall apart. When out_ready is low while a result
// waits, the back pipeline holds, the queue fills, then in_ready drops.
// Reset (rst_n low, synchronous) clears all valid bits and loads the
// configuration defaults.
module easing_curve_evaluator_unit
  import ece_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [VW-1:0] in_time_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] out_eased_value,
  output logic [1:0]    out_segment,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  ece_in_if  in_ch ();
  ece_out_if out_ch ();
  ece_cfg_if cfg_ch ();

  assign in_ch.valid   = in_valid;
  assign in_ch.time_in = in_time_in;
  assign in_ready      = in_ch.ready;
  assign out_valid       = out_ch.valid;
  assign out_eased_value = out_ch.eased_value;
  assign out_segment     = out_ch.segment;
  assign out_ch.ready    = out_ready;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.index = cfg_index;
  assign cfg_ch.data  = cfg_data;
  assign cfg_ready    = cfg_ch.ready;

  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj_data, bj_data;

  ece_front u_front (
    .clk, .rst_n, .cfg(cfg_ch),
    .t_valid(in_ch.valid), .t_in(in_ch.time_in), .t_ready(in_ch.ready),
    .j_valid(fj_valid), .j_data(fj_data), .j_ready(fj_ready)
  );

  ece_fifo u_fifo (
    .clk, .rst_n,
    .w_valid(fj_valid), .w_data(fj_data), .w_ready(fj_ready),
    .r_valid(bj_valid), .r_data(bj_data), .r_ready(bj_ready)
  );

  ece_back u_back (
    .clk, .rst_n,
    .j_valid(bj_valid), .j_data(bj_data), .j_ready(bj_ready),
    .out_ch(out_ch)
  );

endmodule

/* sv/ece_front.sv */
module ece_front
  import ece_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ece_cfg_if.sink       cfg,
  input  logic          t_valid,
  input  logic [VW-1:0] t_in,
  output logic          t_ready,
  output logic          j_valid,
  output job_t          j_data,
  input  logic          j_ready
);

  logic [1:0]    mode_r;
  logic [VW-1:0] p1x_r, p1y_r, p2x_r, p2y_r, p3x_r, p3y_r, p4y_r;
  logic          v_r;
  job_t          job_r, job_nxt;

  assign cfg.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SLOW_OUT;
      p1x_r <= 16'd16384; p1y_r <= 16'd26214; p2x_r <= 16'd20480;
      p2y_r <= 16'd32768; p3x_r <= 16'd22938; p3y_r <= 16'd26214;
      p4y_r <= 16'd32768;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CURVE_MODE: mode_r <= cfg.data[1:0];
        REG_POINT1_X:   p1x_r <= cfg.data;
        REG_POINT1_Y:   p1y_r <= cfg.data;
        REG_POINT2_X:   p2x_r <= cfg.data;
        REG_POINT2_Y:   p2y_r <= cfg.data;
        REG_POINT3_X:   p3x_r <= cfg.data;
        REG_POINT3_Y:   p3y_r <= cfg.data;
        REG_POINT4_Y:   p4y_r <= cfg.data;
        default: ;
      endcase
    end
  end

  // Classify t into a segment and pick its numerator, width and y points
  always_comb begin
    logic [VW:0] n, d;
    n = '0; d = '0;
    job_nxt = '0;
    if (mode_r == MODE_SLOW_OUT) begin
      if (t_in <= p1x_r) begin
        job_nxt.seg = 2'd0; n = {1'b0, t_in}; d = {1'b0, p1x_r};
        job_nxt.quad = 1'b0; job_nxt.ya = '0; job_nxt.yb = p1y_r;
      end else begin
        job_nxt.seg = 2'd1; n = {1'b0, t_in} - {1'b0, p1x_r};
        d = {1'b0, ONE} - {1'b0, p1x_r};
        job_nxt.quad = 1'b1; job_nxt.ya = p1y_r; job_nxt.yb = p2y_r; job_nxt.yc = ONE;
      end
    end else if (t_in <= p2x_r) begin
      job_nxt.seg = 2'd0; n = {1'b0, t_in}; d = {1'b0, p2x_r};
      job_nxt.quad = 1'b1; job_nxt.ya = '0; job_nxt.yb = p1y_r; job_nxt.yc = p2y_r;
    end else if (mode_r == MODE_SLOW_IN) begin
      job_nxt.seg = 2'd1; n = {1'b0, t_in} - {1'b0, p2x_r};
      d = {1'b0, ONE} - {1'b0, p2x_r};
      job_nxt.quad = 1'b0; job_nxt.ya = p2y_r; job_nxt.yb = ONE;
    end else if (t_in <= p3x_r) begin
      job_nxt.seg = 2'd1; n = {1'b0, t_in} - {1'b0, p2x_r};
      d = {1'b0, p3x_r} - {1'b0, p2x_r};
      job_nxt.quad = 1'b0; job_nxt.ya = p2y_r; job_nxt.yb = p3y_r;
    end else begin
      job_nxt.seg = 2'd2; n = {1'b0, t_in} - {1'b0, p3x_r};
      d = {1'b0, ONE} - {1'b0, p3x_r};
      job_nxt.quad = 1'b1; job_nxt.ya = p3y_r; job_nxt.yb = p4y_r; job_nxt.yc = ONE;
    end
    // non-positive width or numerator gives fraction zero
    job_nxt.zero = d[VW] || (d == '0) || (n == '0);
    job_nxt.num = n[VW-1:0];
    job_nxt.den = d[VW-1:0];
  end

  assign t_ready = !v_r || j_ready;

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (t_ready) begin
      v_r <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (t_ready && t_valid) begin
      job_r <= job_nxt;
    end
  end

  assign j_valid = v_r;
  assign j_data  = job_r;

endmodule

/* sv/ece_fifo.sv */
module ece_fifo
  import ece_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic w_valid,
  input  job_t w_data,
  output logic w_ready,
  output logic r_valid,
  output job_t r_data,
  input  logic r_ready
);

  // Two-entry queue, registers only
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign w_ready = cnt_r != 2'd2;
  assign r_valid = cnt_r != 2'd0;
  assign r_data  = mem_r[rp_r];
  assign wr = w_valid && w_ready;
  assign rd = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= w_data;
  end

endmodule

/* sv/ece_back.sv */
module ece_back
  import ece_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic j_valid,
  input  job_t j_data,
  output logic j_ready,
  ece_out_if.source out_ch
);

  localparam int DS = QW;          // one quotient bit per stage
  localparam int LAT = DS + 4;     // divide, weights, products, sum

  typedef struct packed {
    logic          quad;
    logic [VW-1:0] ya;
    logic [VW-1:0] yb;
    logic [VW-1:0] yc;
    logic [1:0]    seg;
  } side_t;

  logic          adv;
  logic [LAT:0]  v_r;

  // Divider pipeline: restoring, one quotient bit per stage
  logic [VW-1:0] rem_r [DS+1];
  logic [QW-1:0] qt_r  [DS+1];
  logic [QW-1:0] nm_r  [DS+1];
  logic [VW-1:0] dv_r  [DS+1];
  logic          zr_r  [DS+1];
  side_t         sd_r  [DS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= '0;
      qt_r[0]  <= '0;
      nm_r[0]  <= {j_data.num, {FRAC_BITS{1'b0}}};
      dv_r[0]  <= j_data.den;
      zr_r[0]  <= j_data.zero;
      sd_r[0]  <= '{j_data.quad, j_data.ya, j_data.yb, j_data.yc, j_data.seg};
    end
  end

  for (genvar g = 0; g < DS; g++) begin : g_div
    logic [VW:0] sh, df;
    assign sh = {rem_r[g], nm_r[g][QW-1]};
    assign df = sh - {1'b0, dv_r[g]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[g+1] <= df[VW] ? sh[VW-1:0] : df[VW-1:0];
        qt_r[g+1]  <= {qt_r[g][QW-2:0], !df[VW]};
        nm_r[g+1]  <= {nm_r[g][QW-2:0], 1'b0};
        dv_r[g+1]  <= dv_r[g];
        zr_r[g+1]  <= zr_r[g];
        sd_r[g+1]  <= sd_r[g];
      end
    end
  end

  // Saturate fraction, then form weights
  logic [VW-1:0] f;
  logic [VW-1:0] s;
  assign f = zr_r[DS] ? '0 : ((qt_r[DS] > QW'(ONE)) ? ONE : qt_r[DS][VW-1:0]);
  assign s = ONE - f;

  logic [VW-1:0] w0_r, w1_r, w2_r;
  side_t         s1_r;
  always_ff @(posedge clk) begin
    logic [2*VW-1:0] ss, sf, ff;
    ss = s * s; sf = s * f; ff = f * f;
    if (adv) begin
      s1_r <= sd_r[DS];
      if (sd_r[DS].quad) begin
        w0_r <= ss[FRAC_BITS +: VW];
        w1_r <= sf[FRAC_BITS-1 +: VW];
        w2_r <= ff[FRAC_BITS +: VW];
      end else begin
        w0_r <= s; w1_r <= f; w2_r <= '0;
      end
    end
  end

  // Weight the y points
  logic [2*VW-1:0] p0_r, p1_r, p2_r;
  logic [1:0]      sg2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r <= w0_r * s1_r.ya;
      p1_r <= w1_r * s1_r.yb;
      p2_r <= w2_r * s1_r.yc;
      sg2_r <= s1_r.seg;
    end
  end

  // Sum, shift and saturate
  logic [2*VW+1:0] sum;
  logic [VW+2:0]   y;
  logic [VW-1:0]   yv_r;
  logic [1:0]      sg3_r;
  assign sum = {2'b0, p0_r} + {2'b0, p1_r} + {2'b0, p2_r};
  assign y = sum[FRAC_BITS +: VW+3];
  always_ff @(posedge clk) begin
    if (adv) begin
      yv_r  <= (y > (VW+3)'(ONE)) ? ONE : y[VW-1:0];
      sg3_r <= sg2_r;
    end
  end

  // Output register
  res_t o_r;
  always_ff @(posedge clk) begin
    if (adv) o_r <= '{yv_r, sg3_r};
  end

  // Pipeline advances whenever the output slot is free or being taken
  assign adv = !v_r[LAT] || out_ch.ready;
  assign j_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-1:0], j_valid};
    end
  end

  assign out_ch.valid       = v_r[LAT];
  assign out_ch.eased_value = o_r.eased_value;
  assign out_ch.segment     = o_r.segment;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ece_pkg::*;

  localparam logic [1:0] MODE_SIGMOID = 2'd2;
  localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;
  localparam int SETTLE_CYCLES = 45;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ece_in_if  in_ch();
  ece_out_if out_ch();
  ece_cfg_if cfg_ch();

  easing_curve_evaluator_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_time_in      (in_ch.time_in),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_eased_value (out_ch.eased_value),
    .out_segment     (out_ch.segment),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the curve registers
  logic [1:0]  sh_mode;
  logic [15:0] sh_p1x, sh_p1y, sh_p2x, sh_p2y, sh_p3x, sh_p3y, sh_p4y;

  logic [15:0] time_queue[$];
  res_t        eased_queue[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  logic        hold_arm = 1'b0;

  // Local fraction of a segment, zero for empty or inverted widths or a non-positive numerator
  function automatic longint unsigned seg_fraction(longint num, longint den);
    longint unsigned f;
    if (den <= 0 || num <= 0) return 0;
    f = (longint'(num) << FRAC_BITS) / den;
    return (f > UNIT) ? UNIT : f;
  endfunction

  function automatic longint unsigned line_mix(longint unsigned f, longint unsigned a,
                                               longint unsigned b);
    longint unsigned s;
    s = UNIT - f;
    return (s * a + f * b) >> FRAC_BITS;
  endfunction

  function automatic longint unsigned bezier2(longint unsigned f, longint unsigned a,
                                              longint unsigned b, longint unsigned c);
    longint unsigned s, w0, w1, w2;
    s  = UNIT - f;
    w0 = (s * s) >> FRAC_BITS;
    w1 = (2 * s * f) >> FRAC_BITS;
    w2 = (f * f) >> FRAC_BITS;
    return (w0 * a + w1 * b + w2 * c) >> FRAC_BITS;
  endfunction

  function automatic res_t eval_curve(logic [15:0] t_in);
    longint t, x1, x2, x3, one;
    longint unsigned f, y;
    res_t r;
    t = t_in; x1 = sh_p1x; x2 = sh_p2x; x3 = sh_p3x; one = UNIT;
    if (sh_mode == MODE_SLOW_OUT) begin
      if (t <= x1) begin
        r.segment = 2'd0;
        f = seg_fraction(t, x1);
        y = (f * sh_p1y) >> FRAC_BITS;
      end else begin
        r.segment = 2'd1;
        f = seg_fraction(t - x1, one - x1);
        y = bezier2(f, sh_p1y, sh_p2y, UNIT);
      end
    end else if (t <= x2) begin
      r.segment = 2'd0;
      f = seg_fraction(t, x2);
      y = bezier2(f, 0, sh_p1y, sh_p2y);
    end else if (sh_mode == MODE_SLOW_IN) begin
      r.segment = 2'd1;
      f = seg_fraction(t - x2, one - x2);
      y = line_mix(f, sh_p2y, UNIT);
    end else if (t <= x3) begin
      r.segment = 2'd1;
      f = seg_fraction(t - x2, x3 - x2);
      y = line_mix(f, sh_p2y, sh_p3y);
    end else begin
      r.segment = 2'd2;
      f = seg_fraction(t - x3, one - x3);
      y = bezier2(f, sh_p3y, sh_p4y, UNIT);
    end
    if (y > UNIT) y = UNIT;
    r.eased_value = y[15:0];
    return r;
  endfunction

  // Track register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      sh_mode <= MODE_SLOW_OUT;
      sh_p1x <= 16'd16384; sh_p1y <= 16'd26214;
      sh_p2x <= 16'd20480; sh_p2y <= 16'd32768;
      sh_p3x <= 16'd22938; sh_p3y <= 16'd26214;
      sh_p4y <= 16'd32768;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_CURVE_MODE: sh_mode <= cfg_ch.data[1:0];
        REG_POINT1_X:   sh_p1x <= cfg_ch.data;
        REG_POINT1_Y:   sh_p1y <= cfg_ch.data;
        REG_POINT2_X:   sh_p2x <= cfg_ch.data;
        REG_POINT2_Y:   sh_p2y <= cfg_ch.data;
        REG_POINT3_X:   sh_p3x <= cfg_ch.data;
        REG_POINT3_Y:   sh_p3y <= cfg_ch.data;
        REG_POINT4_Y:   sh_p4y <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Driver: offer pending items with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.time_in <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (time_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.time_in <= time_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted item
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      eased_queue.push_back(eval_curve(in_ch.time_in));
  end

  // Long hold-off counter for back-pressure
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_arm) hold_left <= 300;
  end

  // Receiver: random stalls, forced low during a hold
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (eased_queue.size() == 0) begin
        $error("unexpected result eased_value=%0d segment=%0d",
               out_ch.eased_value, out_ch.segment);
        fail_count++;
      end else begin
        exp_r = eased_queue.pop_front();
        if (out_ch.eased_value !== exp_r.eased_value) begin
          $error("eased_value expected %0d actual %0d", exp_r.eased_value,
                 out_ch.eased_value);
          fail_count++;
        end
        if (out_ch.segment !== exp_r.segment) begin
          $error("segment expected %0d actual %0d", exp_r.segment, out_ch.segment);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (time_queue.size() != 0 || in_ch.valid || eased_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_curve(logic [15:0] mode, logic [15:0] p1x, logic [15:0] p1y,
                            logic [15:0] p2x, logic [15:0] p2y, logic [15:0] p3x,
                            logic [15:0] p3y, logic [15:0] p4y);
    write_reg(REG_CURVE_MODE, mode);
    write_reg(REG_POINT1_X, p1x);
    write_reg(REG_POINT1_Y, p1y);
    write_reg(REG_POINT2_X, p2x);
    write_reg(REG_POINT2_Y, p2y);
    write_reg(REG_POINT3_X, p3x);
    write_reg(REG_POINT3_Y, p3y);
    write_reg(REG_POINT4_Y, p4y);
  endtask

  function automatic logic [15:0] rand_point();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  // Random times, mostly in the unit range, some near breakpoints
  task automatic queue_times(int count);
    logic [15:0] t;
    repeat (count) begin
      case ($urandom_range(9))
        0: t = 16'($urandom_range(65535));
        1: t = sh_p1x + 16'($urandom_range(4)) - 16'd2;
        2: t = sh_p2x + 16'($urandom_range(4)) - 16'd2;
        3: t = sh_p3x + 16'($urandom_range(4)) - 16'd2;
        default: t = 16'($urandom_range(32768));
      endcase
      time_queue.push_back(t);
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.time_in = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset curve, field extremes and breakpoints
    time_queue.push_back(16'd0);     time_queue.push_back(16'd1);
    time_queue.push_back(16'd16383); time_queue.push_back(16'd16384);
    time_queue.push_back(16'd16385); time_queue.push_back(16'd20480);
    time_queue.push_back(16'd32767); time_queue.push_back(16'd32768);
    time_queue.push_back(16'd32769); time_queue.push_back(16'd65535);
    time_queue.push_back(16'hAAAA);  time_queue.push_back(16'h5555);
    drain();

    // Directed: zero-width and inverted segments, y beyond one, spare mode code
    load_curve(16'hFFFF, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535,
               16'd65535);
    time_queue.push_back(16'd0);     time_queue.push_back(16'd1);
    time_queue.push_back(16'd32768); time_queue.push_back(16'd65535);
    drain();
    load_curve(16'(MODE_SIGMOID), 16'd32768, 16'd0, 16'd30000, 16'd0, 16'd10000,
               16'd32768, 16'd0);
    time_queue.push_back(16'd0);     time_queue.push_back(16'd10000);
    time_queue.push_back(16'd30000); time_queue.push_back(16'd30001);
    time_queue.push_back(16'd32768);
    drain();
    load_curve(16'(MODE_SLOW_OUT), 16'd32768, 16'd32768, 16'd32768, 16'd0, 16'd32768,
               16'd0, 16'd0);
    time_queue.push_back(16'd0);     time_queue.push_back(16'd32768);
    time_queue.push_back(16'd32769); time_queue.push_back(16'd40000);
    drain();

    // Random phases across curve settings and idle patterns
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      load_curve(16'($urandom_range(65535)), rand_point(), rand_point(), rand_point(),
                 rand_point(), rand_point(), rand_point(), rand_point());
      if (ph == 4) hold_arm <= 1'b1;
      queue_times(105);
      if (ph == 4) begin
        while (hold_left == 0) @(posedge clk);
        hold_arm <= 1'b0;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("easing_curve_evaluator_unit verification clean");
    end else begin
      $display("easing_curve_evaluator_unit verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("easing_curve_evaluator_unit verification failed");
    $finish;
  end

endmodule

/* files.f */
sv/ece_pkg.sv
sv/ece_if.sv
sv/ece_front.sv
sv/ece_fifo.sv
sv/ece_back.sv
sv/easing_curve_evaluator_unit.sv
tb/tb.sv
